### rtl/hiitb_pkg.sv
// ----------------------------------------------------------------------------
// hiitb_pkg
// Shared types, register offsets and the power-on image of the I/O page.
// ----------------------------------------------------------------------------
package hiitb_pkg;

    localparam int PAGE_BYTES = 256;
    localparam int ADDR_W     = $clog2(PAGE_BYTES);

    // Fixed register offsets within the page.
    localparam logic [7:0] OFS_JOYPAD = 8'h00;
    localparam logic [7:0] OFS_DIV    = 8'h04;
    localparam logic [7:0] OFS_TIMA   = 8'h05;
    localparam logic [7:0] OFS_TMA    = 8'h06;
    localparam logic [7:0] OFS_FLAGS  = 8'h0F;
    localparam logic [7:0] OFS_LINE   = 8'h44;
    localparam logic [7:0] OFS_DMA    = 8'h46;
    localparam logic [7:0] OFS_ENABLE = 8'hFF;

    localparam logic [7:0] JOYP_SEL_DIR = 8'h20;
    localparam logic [7:0] JOYP_SEL_BTN = 8'h10;
    localparam logic [7:0] JOYP_DIR_VAL = ~JOYP_SEL_BTN;
    localparam logic [7:0] JOYP_BTN_VAL = ~JOYP_SEL_DIR;

    localparam logic [3:0] IRQ_SRC_MASK = 4'hF;
    localparam logic [7:0] FLAG_VBLANK  = 8'h01;
    localparam logic [7:0] FLAG_LCD     = 8'h02;
    localparam logic [7:0] FLAG_TIMER   = 8'h04;
    localparam logic [2:0] VECTOR_BASE  = 3'b010;

    localparam logic [8:0] LINE_COUNT    = 9'd154;
    localparam logic [7:0] VISIBLE_LINES = 8'd144;

    typedef enum logic [2:0] {
        OP_READ      = 3'd0,
        OP_WRITE     = 3'd1,
        OP_TIMER     = 3'd2,
        OP_LINE      = 3'd3,
        OP_DIVIDER   = 3'd4,
        OP_IRQ_CHECK = 3'd5,
        OP_LCD_FLAG  = 3'd6
    } t_op;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] io_address;
        logic [7:0] write_data;
        logic       master_enable;
        logic       cpu_halted;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       service_taken;
        logic [7:0] service_vector;
        logic       wake_only;
        logic       draw_line;
        logic       dma_start;
        logic [7:0] dma_page;
    } t_result;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_page_req;

    localparam logic [7:0] POWER_ON [PAGE_BYTES] = '{
        8'hCF,8'h00,8'h7E,8'hFF,8'hD3,8'h00,8'h00,8'hF8,
        8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hE1,
        8'h80,8'hBF,8'hF3,8'hFF,8'hBF,8'hFF,8'h3F,8'h00,
        8'hFF,8'hBF,8'h7F,8'hFF,8'h9F,8'hFF,8'hBF,8'hFF,
        8'hFF,8'h00,8'h00,8'hBF,8'h77,8'hF3,8'hF1,8'hFF,
        8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
        8'h71,8'h72,8'hD5,8'h91,8'h58,8'hBB,8'h2A,8'hFA,
        8'hCF,8'h3C,8'h54,8'h75,8'h48,8'hCF,8'h8F,8'hD9,
        8'h00,8'h80,8'h00,8'h00,8'h00,8'h00,8'hFF,8'hFC,
        8'hFF,8'hFF,8'h00,8'h00,8'hFF,8'hFF,8'hFF,8'hFF,
        8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
        8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
        8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
        8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
        8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
        8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,8'hFF,
        8'h2B,8'h0B,8'h64,8'h2F,8'hAF,8'h15,8'h60,8'h6D,
        8'h61,8'h4E,8'hAC,8'h45,8'h0F,8'hDA,8'h92,8'hF3,
        8'h83,8'h38,8'hE4,8'h4E,8'hA7,8'h6C,8'h38,8'h58,
        8'hBE,8'hEA,8'hE5,8'h81,8'hB4,8'hCB,8'hBF,8'h7B,
        8'h59,8'hAD,8'h50,8'h13,8'h5E,8'hF6,8'hB3,8'hC1,
        8'hDC,8'hDF,8'h9E,8'h68,8'hD7,8'h59,8'h26,8'hF3,
        8'h62,8'h54,8'hF8,8'h36,8'hB7,8'h78,8'h6A,8'h22,
        8'hA7,8'hDD,8'h88,8'h15,8'hCA,8'h96,8'h39,8'hD3,
        8'hE6,8'h55,8'h6E,8'hEA,8'h90,8'h76,8'hB8,8'hFF,
        8'h50,8'hCD,8'hB5,8'h1B,8'h1F,8'hA5,8'h4D,8'h2E,
        8'hB4,8'h09,8'h47,8'h8A,8'hC4,8'h5A,8'h8C,8'h4E,
        8'hE7,8'h29,8'h50,8'h88,8'hA8,8'h66,8'h85,8'h4B,
        8'hAA,8'h38,8'hE7,8'h6B,8'h45,8'h3E,8'h30,8'h37,
        8'hBA,8'hC5,8'h31,8'hF2,8'h71,8'hB4,8'hCF,8'h29,
        8'hBC,8'h7F,8'h7E,8'hD0,8'hC7,8'hC3,8'hBD,8'hCF,
        8'h59,8'hEA,8'h39,8'h01,8'h2E,8'h00,8'h69,8'h00
    };

endpackage

### rtl/handheld_io_interrupt_timer_block.sv
// ----------------------------------------------------------------------------
// handheld_io_interrupt_timer_block
// I/O register page with timer, divider, line counter and interrupt dispatch.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                  Payload
//  input    in         i_in_valid / o_in_ready    i_in_item   (t_item)
//  output   out        o_out_valid / i_out_ready  o_out_item  (t_result)
//
//  One transaction is accepted per cycle unless the output stalls; its result
//  is valid once it has passed the input register and the result register.
//  The input register and the page memory read register load together at
//  acceptance; the result register loads when the input stage advances. Plain
//  page bytes are written at acceptance. Per-entry written bits make the page
//  read its power-on image, so no clearing pass is needed. A stalled output
//  holds the pipeline and drops o_in_ready once the input stage is occupied.
// ----------------------------------------------------------------------------
module handheld_io_interrupt_timer_block
    import hiitb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_item   i_in_item,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_out_item
);

    logic      r_s1_valid;
    t_item     r_s1_item;
    logic      r_out_valid;
    t_result   r_out;
    logic      advance;
    logic      accept;
    t_page_req page_req;
    logic [7:0] page_byte;

    logic [7:0] r_joyp, r_div, r_tima, r_tma, r_flags, r_line, r_enable;
    logic [7:0] n_joyp, n_div, n_tima, n_tma, n_flags, n_line, n_enable;
    t_result    n_out;

    logic [7:0] tima_inc;
    logic [8:0] line_sum;
    logic [8:0] line_wrap;
    logic [7:0] line_next;
    logic [3:0] pending;

    assign advance    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || advance;
    assign accept     = i_in_valid && o_in_ready;

    // Plain bytes are stored as written, so the store is updated at acceptance.
    always_comb begin
        page_req.rd_en = accept;
        page_req.wr_en = accept && (t_op'(i_in_item.operation) == OP_WRITE);
        page_req.addr  = i_in_item.io_address[ADDR_W-1:0];
        page_req.data  = i_in_item.write_data;
    end

    hiitb_page u_page (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (page_req),
        .o_rd_byte (page_byte)
    );

    assign tima_inc  = r_tima + 8'd1;
    assign line_sum  = {1'b0, r_line} + 9'd1;
    assign line_wrap = line_sum - LINE_COUNT;
    assign line_next = (line_sum >= LINE_COUNT) ? line_wrap[7:0] : line_sum[7:0];
    assign pending   = r_flags[3:0] & r_enable[3:0] & IRQ_SRC_MASK;

    always_comb begin
        n_joyp   = r_joyp;
        n_div    = r_div;
        n_tima   = r_tima;
        n_tma    = r_tma;
        n_flags  = r_flags;
        n_line   = r_line;
        n_enable = r_enable;
        n_out    = '0;
        case (t_op'(r_s1_item.operation))
            OP_READ: begin
                case (r_s1_item.io_address)
                    OFS_JOYPAD: n_out.read_data = r_joyp;
                    OFS_DIV:    n_out.read_data = r_div;
                    OFS_TIMA:   n_out.read_data = r_tima;
                    OFS_TMA:    n_out.read_data = r_tma;
                    OFS_FLAGS:  n_out.read_data = r_flags;
                    OFS_LINE:   n_out.read_data = r_line;
                    OFS_ENABLE: n_out.read_data = r_enable;
                    default:    n_out.read_data = page_byte;
                endcase
            end
            OP_WRITE: begin
                case (r_s1_item.io_address)
                    OFS_JOYPAD: begin
                        if (r_s1_item.write_data == JOYP_SEL_DIR) begin
                            n_joyp = JOYP_DIR_VAL;
                        end else if (r_s1_item.write_data == JOYP_SEL_BTN) begin
                            n_joyp = JOYP_BTN_VAL;
                        end else begin
                            n_joyp = r_s1_item.write_data;
                        end
                    end
                    OFS_DIV:    n_div    = '0;
                    OFS_TIMA:   n_tima   = r_s1_item.write_data;
                    OFS_TMA:    n_tma    = r_s1_item.write_data;
                    OFS_FLAGS:  n_flags  = r_s1_item.write_data;
                    OFS_LINE:   n_line   = '0;
                    OFS_ENABLE: n_enable = r_s1_item.write_data;
                    OFS_DMA: begin
                        n_out.dma_start = 1'b1;
                        n_out.dma_page  = r_s1_item.write_data;
                    end
                    default: ;
                endcase
            end
            OP_TIMER: begin
                if (tima_inc == 8'd0) begin
                    n_tima  = r_tma;
                    n_flags = r_flags | FLAG_TIMER;
                end else begin
                    n_tima = tima_inc;
                end
            end
            OP_LINE: begin
                n_line = line_next;
                if (line_next < VISIBLE_LINES) begin
                    n_out.draw_line = 1'b1;
                end else if (line_next == VISIBLE_LINES) begin
                    n_flags = r_flags | FLAG_VBLANK;
                end
            end
            OP_DIVIDER: n_div = r_div + 8'd1;
            OP_IRQ_CHECK: begin
                if (pending != 4'd0) begin
                    if (r_s1_item.master_enable) begin
                        n_out.service_taken = 1'b1;
                        // The lowest pending source wins.
                        if (pending[0]) begin
                            n_flags[0] = 1'b0;
                            n_out.service_vector = {VECTOR_BASE, 2'd0, 3'b000};
                        end else if (pending[1]) begin
                            n_flags[1] = 1'b0;
                            n_out.service_vector = {VECTOR_BASE, 2'd1, 3'b000};
                        end else if (pending[2]) begin
                            n_flags[2] = 1'b0;
                            n_out.service_vector = {VECTOR_BASE, 2'd2, 3'b000};
                        end else begin
                            n_flags[3] = 1'b0;
                            n_out.service_vector = {VECTOR_BASE, 2'd3, 3'b000};
                        end
                    end else if (r_s1_item.cpu_halted) begin
                        n_out.wake_only = 1'b1;
                    end
                end
            end
            OP_LCD_FLAG: n_flags = r_flags | FLAG_LCD;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_joyp      <= POWER_ON[OFS_JOYPAD];
            r_div       <= POWER_ON[OFS_DIV];
            r_tima      <= POWER_ON[OFS_TIMA];
            r_tma       <= POWER_ON[OFS_TMA];
            r_flags     <= POWER_ON[OFS_FLAGS];
            r_line      <= POWER_ON[OFS_LINE];
            r_enable    <= POWER_ON[OFS_ENABLE];
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_joyp      <= n_joyp;
                r_div       <= n_div;
                r_tima      <= n_tima;
                r_tma       <= n_tma;
                r_flags     <= n_flags;
                r_line      <= n_line;
                r_enable    <= n_enable;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item <= i_in_item;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

### rtl/hiitb_page.sv
// ----------------------------------------------------------------------------
// hiitb_page
// Byte store for the plain registers of the I/O page, with power-on image.
// ----------------------------------------------------------------------------
module hiitb_page
    import hiitb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_page_req i_req,
    output logic [7:0] o_rd_byte
);

    logic [7:0]            r_mem [PAGE_BYTES];
    logic [PAGE_BYTES-1:0] r_written;
    logic [7:0]            r_q;
    logic                  r_hit;
    logic [ADDR_W-1:0]     r_addr;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.data;
        end
        if (i_req.rd_en) begin
            r_q    <= r_mem[i_req.addr];
            r_addr <= i_req.addr;
        end
    end

    // An entry never written since reset still reads as its power-on value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
            r_hit     <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_written[i_req.addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_hit <= r_written[i_req.addr];
            end
        end
    end

    assign o_rd_byte = r_hit ? r_q : POWER_ON[r_addr];

endmodule
